// ----- rtl/mcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

  // Coordinate width of the centre and radius registers.
  localparam int COORD_BITS = 10;
  // Pixel coordinates carry one extra bit of range and a sign bit.
  localparam int OUT_BITS   = COORD_BITS + 2;
  // The midpoint decision value, two's complement.
  localparam int DEC_BITS   = COORD_BITS + 3;

  // Eight symmetric pixels are emitted for each group.
  localparam int PIXELS     = 8;
  localparam int IDX_BITS   = $clog2(PIXELS);

  // Depth of the queue between the front and back parts.
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  // Configuration port geometry.
  localparam int DATA_BITS    = 32;
  localparam int REG_IDX_BITS = 2;
  localparam int ADDR_BITS    = REG_IDX_BITS + 2;

  // Register indexes.
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_RADIUS   = REG_IDX_BITS'(2);

  // Configuration register contents.
  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
  } cfg_t;

  // One group of eight pixels: the octant offsets and the end-of-circle flag.
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  done;
  } group_t;

endpackage

`default_nettype wire

// ----- rtl/mcr_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcr_regs
  import mcr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  // Register writes; bits above the coordinate width are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CENTER_X: cfg.center_x <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y: cfg.center_y <= pwdata[COORD_BITS-1:0];
        REG_RADIUS:   cfg.radius   <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = DATA_BITS'(cfg.center_x);
      REG_CENTER_Y: prdata = DATA_BITS'(cfg.center_y);
      REG_RADIUS:   prdata = DATA_BITS'(cfg.radius);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/mcr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcr_front
  import mcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   restart,
  input  cfg_t   cfg,
  output logic   push,
  output group_t push_data,
  input  logic   q_full
);

  logic                  accept;
  logic [COORD_BITS-1:0] offset_x;
  logic [COORD_BITS-1:0] offset_y;
  logic [DEC_BITS-1:0]   decision;
  logic                  active;
  logic [COORD_BITS-1:0] offset_x_next;
  logic [COORD_BITS-1:0] offset_y_next;
  logic [DEC_BITS-1:0]   decision_next;
  logic                  done_next;
  logic                  step;

  // A word is taken whenever the queue has room for its group.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign step     = active && (offset_x < offset_y);
  assign push     = accept && (restart || step);

  // One midpoint iteration, or the initial load on restart.
  always_comb begin
    if (restart) begin
      offset_x_next = '0;
      offset_y_next = cfg.radius;
      decision_next = DEC_BITS'(1) - DEC_BITS'(cfg.radius);
    end else begin
      offset_x_next = offset_x + COORD_BITS'(1);
      if (decision[DEC_BITS-1]) begin
        offset_y_next = offset_y;
        decision_next = decision + DEC_BITS'({offset_x_next, 1'b1});
      end else begin
        offset_y_next = offset_y - COORD_BITS'(1);
        decision_next = decision + DEC_BITS'({offset_x_next, 1'b1})
                        - DEC_BITS'({offset_y_next, 1'b0});
      end
    end
    done_next = (offset_x_next >= offset_y_next);
  end

  assign push_data.x    = offset_x_next;
  assign push_data.y    = offset_y_next;
  assign push_data.done = done_next;

  // Iteration state is updated only by words that emit a group.
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      decision <= '0;
      active   <= 1'b0;
    end else if (push) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
      active   <= !done_next;
    end
  end

  // While a circle is in progress the octant walk has not crossed the diagonal.
  a_active_below_diag: assert property (@(posedge clk) disable iff (rst)
    active |-> (offset_x < offset_y))
    else $error("circle active past the diagonal");

  // A group is never offered to a full queue.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("group pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/mcr_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcr_queue
  import mcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output group_t q_data
);

  group_t                entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == Q_CNT_BITS'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mcr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mcr_back
  import mcr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       q_valid,
  input  group_t                     q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] pixel_x,
  output logic signed [OUT_BITS-1:0] pixel_y,
  output logic                       last_of_step,
  output logic                       circle_done
);

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIXELS - 1);

  group_t                desc;
  logic                  busy;
  logic [IDX_BITS-1:0]   idx;
  logic                  load;
  logic                  last;
  logic [OUT_BITS-1:0]   cx_e;
  logic [OUT_BITS-1:0]   cy_e;
  logic [OUT_BITS-1:0]   a_e;
  logic [OUT_BITS-1:0]   b_e;
  logic [OUT_BITS-1:0]   px;
  logic [OUT_BITS-1:0]   py;

  // The output register takes a pixel when it is empty or being drained.
  assign load = busy && (!out_valid || out_ready);
  assign last = (idx == LAST_IDX);
  // The next group is fetched as the last pixel of the current one is loaded.
  assign pop  = q_valid && (!busy || (load && last));

  // Octant mirroring: bit 2 swaps the axes, bit 0 negates x, bit 1 negates y.
  always_comb begin
    cx_e = OUT_BITS'(cfg.center_x);
    cy_e = OUT_BITS'(cfg.center_y);
    a_e  = idx[2] ? OUT_BITS'(desc.y) : OUT_BITS'(desc.x);
    b_e  = idx[2] ? OUT_BITS'(desc.x) : OUT_BITS'(desc.y);
    px   = idx[0] ? (cx_e - a_e) : (cx_e + a_e);
    py   = idx[1] ? (cy_e - b_e) : (cy_e + b_e);
  end

  // Pixel sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid    <= 1'b1;
        pixel_x      <= px;
        pixel_y      <= py;
        last_of_step <= last;
        circle_done  <= last && desc.done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        desc <= q_data;
        idx  <= '0;
      end else if (load) begin
        idx <= idx + IDX_BITS'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The end-of-circle flag only ever marks the closing pixel of a group.
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && circle_done) |-> last_of_step)
    else $error("circle_done outside the last pixel of a group");

  // The sequencer goes idle only after loading the eighth pixel.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(load && last))
    else $error("pixel sequencer stopped mid-group");

endmodule

`default_nettype wire

// ----- rtl/midpoint_circle_rasterizer_top.sv -----
// A taken word's group is written to the queue, fetched into the back part's group
// register and mirrored into the single pixel output register, which paces output.
// Words emitting nothing use no queue entry; a two-deep group queue lets input run ahead.
// Reset (rst, synchronous, active high) clears the registers, the circle state,
// the queue and the output valid; no circle is in progress afterwards.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_rasterizer_top
  import mcr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_BITS-1:0]       paddr,
  input  logic [DATA_BITS-1:0]       pwdata,
  output logic [DATA_BITS-1:0]       prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       restart,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_BITS-1:0] pixel_x,
  output logic signed [OUT_BITS-1:0] pixel_y,
  output logic                       last_of_step,
  output logic                       circle_done
);

  cfg_t   cfg;
  logic   push;
  group_t push_data;
  logic   q_full;
  logic   pop;
  logic   q_valid;
  group_t q_data;

  // Configuration registers.
  mcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Front part: takes words and runs the midpoint iteration.
  mcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Group queue between the two parts.
  mcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back part: emits the eight mirrored pixels of each group.
  mcr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

`default_nettype wire
